FILE: sv/cbn_pkg.sv
// Shared types, constants and helpers for the CSMA/CD backoff station.
package cbn_pkg;

  // Field widths
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned DRAW_W     = 10;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned ID_W       = 8;
  localparam int unsigned SCALE_W    = 8;
  localparam int unsigned BACKOFF_W  = 18;
  localparam int unsigned SLOTS_W    = 12;
  localparam int unsigned COLL_W     = 4;

  // Stream and register bus widths
  localparam int unsigned S_TDATA_W  = 16;
  localparam int unsigned M_TDATA_W  = 16;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;

  // Retry limits
  localparam logic [COLL_W-1:0] MAX_ATTEMPTS = 4'd15;
  localparam logic [COLL_W-1:0] BACKOFF_CAP  = 4'd10;

  // Register reset values
  localparam logic [LEN_W-1:0]   MEDIUM_LENGTH_RST = 11'd8;
  localparam logic [ID_W-1:0]    NODE_ID_RST       = 8'd1;
  localparam logic [SCALE_W-1:0] WAIT_SCALE_RST    = 8'd1;

  // Register indexes (word address)
  localparam logic [1:0] REG_MEDIUM_LENGTH = 2'd0;
  localparam logic [1:0] REG_NODE_ID       = 2'd1;
  localparam logic [1:0] REG_WAIT_SCALE    = 2'd2;

  // Event kinds
  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK      = 2'd0,
    FUNC_FREE      = 2'd1,
    FUNC_COLLISION = 2'd2,
    FUNC_BLOCKED   = 2'd3
  } func_e;

  // Configuration seen by the station core
  typedef struct packed {
    logic [LEN_W-1:0]   medium_length;
    logic [ID_W-1:0]    node_id;
    logic [SCALE_W-1:0] wait_scale;
    logic               length_wr;     // medium_length written at the previous edge
  } cfg_t;

  // One result word
  typedef struct packed {
    logic            gave_up;
    logic            free_ack;
    logic [ID_W-1:0] sent_id;
  } result_t;

  // Station status for checks
  typedef struct packed {
    logic              stopped;
    logic [COLL_W-1:0] collisions;
  } status_t;

  // Low-bit mask of k ones, k up to DRAW_W
  function automatic logic [DRAW_W-1:0] backoff_mask(input logic [COLL_W-1:0] k);
    logic [DRAW_W-1:0] m;
    m = '0;
    for (int i = 0; i < DRAW_W; i++) begin
      m[i] = (COLL_W'(i) < k);
    end
    return m;
  endfunction

endpackage

FILE: sv/cbn_apb_regs.sv
// APB configuration registers of the backoff station.
module cbn_apb_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cbn_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [cbn_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [cbn_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output cbn_pkg::cfg_t                     cfg_o
);

  logic [cbn_pkg::LEN_W-1:0]   medium_length_q, medium_length_d;
  logic [cbn_pkg::ID_W-1:0]    node_id_q, node_id_d;
  logic [cbn_pkg::SCALE_W-1:0] wait_scale_q, wait_scale_d;
  logic                        length_wr_q, length_wr_d;
  logic                        wr_en;
  logic [1:0]                  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  // Write decode
  always_comb begin
    medium_length_d = medium_length_q;
    node_id_d       = node_id_q;
    wait_scale_d    = wait_scale_q;
    if (wr_en) begin
      unique case (reg_idx)
        cbn_pkg::REG_MEDIUM_LENGTH: medium_length_d = pwdata[cbn_pkg::LEN_W-1:0];
        cbn_pkg::REG_NODE_ID:       node_id_d       = pwdata[cbn_pkg::ID_W-1:0];
        cbn_pkg::REG_WAIT_SCALE:    wait_scale_d    = pwdata[cbn_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Reload strobe lands once the new length is in its register
  assign length_wr_d = wr_en && (reg_idx == cbn_pkg::REG_MEDIUM_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      medium_length_q <= cbn_pkg::MEDIUM_LENGTH_RST;
      node_id_q       <= cbn_pkg::NODE_ID_RST;
      wait_scale_q    <= cbn_pkg::WAIT_SCALE_RST;
      length_wr_q     <= 1'b0;
    end else begin
      medium_length_q <= medium_length_d;
      node_id_q       <= node_id_d;
      wait_scale_q    <= wait_scale_d;
      length_wr_q     <= length_wr_d;
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      cbn_pkg::REG_MEDIUM_LENGTH: prdata = cbn_pkg::APB_DATA_W'(medium_length_q);
      cbn_pkg::REG_NODE_ID:       prdata = cbn_pkg::APB_DATA_W'(node_id_q);
      cbn_pkg::REG_WAIT_SCALE:    prdata = cbn_pkg::APB_DATA_W'(wait_scale_q);
      default:                    prdata = '0;
    endcase
  end

  // Slot counter reloads when the medium length is written
  assign cfg_o.medium_length = medium_length_q;
  assign cfg_o.node_id       = node_id_q;
  assign cfg_o.wait_scale    = wait_scale_q;
  assign cfg_o.length_wr     = length_wr_q;

endmodule

FILE: sv/cbn_core.sv
// Station state and the combinational event update.
module cbn_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  cbn_pkg::func_e                func_i,
  input  logic [cbn_pkg::DRAW_W-1:0]    draw_i,
  input  cbn_pkg::cfg_t                 cfg_i,
  output cbn_pkg::result_t              result_o,
  output cbn_pkg::status_t              status_o
);

  logic                            stopped_q, stopped_d;
  logic [cbn_pkg::BACKOFF_W-1:0]   backoff_q, backoff_d;
  logic                            coll_seen_q, coll_seen_d;
  logic                            in_coll_q, in_coll_d;
  logic                            blocked_q, blocked_d;
  logic                            delivered_q, delivered_d;
  logic                            final_pass_q, final_pass_d;
  logic [cbn_pkg::SLOTS_W-1:0]     slots_q, slots_d;
  logic [cbn_pkg::COLL_W-1:0]      coll_q, coll_d;

  logic [cbn_pkg::SLOTS_W-1:0]     frame_slots;
  logic [cbn_pkg::BACKOFF_W-1:0]   backoff_dec;
  logic [cbn_pkg::COLL_W-1:0]      coll_inc;
  logic [cbn_pkg::COLL_W-1:0]      exp_k;
  logic [cbn_pkg::DRAW_W-1:0]      draw_masked;
  logic [cbn_pkg::BACKOFF_W-1:0]   backoff_new;

  assign frame_slots = {cfg_i.medium_length, 1'b0};
  assign backoff_dec = (backoff_q != '0) ? backoff_q - 1'b1 : backoff_q;
  assign coll_inc    = (coll_q < cbn_pkg::MAX_ATTEMPTS) ? coll_q + 1'b1 : coll_q;
  assign exp_k       = (coll_inc < cbn_pkg::BACKOFF_CAP) ? coll_inc : cbn_pkg::BACKOFF_CAP;
  assign draw_masked = draw_i & cbn_pkg::backoff_mask(exp_k);
  // 10x8 product fits the 18-bit delay exactly
  assign backoff_new = cbn_pkg::BACKOFF_W'(draw_masked) *
                       cbn_pkg::BACKOFF_W'(cfg_i.wait_scale);

  // Event update
  always_comb begin
    stopped_d    = stopped_q;
    backoff_d    = backoff_q;
    coll_seen_d  = coll_seen_q;
    in_coll_d    = in_coll_q;
    blocked_d    = blocked_q;
    delivered_d  = delivered_q;
    final_pass_d = final_pass_q;
    slots_d      = slots_q;
    coll_d       = coll_q;
    result_o     = '0;

    if (step_i) begin
      unique case (func_i)
        cbn_pkg::FUNC_TICK: begin
          if (!stopped_q) begin
            backoff_d = backoff_dec;
            if (backoff_dec != '0) begin
              // still waiting out the delay
            end else if (in_coll_q) begin
              if (!coll_seen_q) begin
                slots_d     = frame_slots;
                coll_seen_d = 1'b1;
              end
            end else if (blocked_q) begin
              blocked_d = 1'b0;
              backoff_d = cbn_pkg::BACKOFF_W'(1);
            end else if (slots_q != '0) begin
              slots_d          = slots_q - 1'b1;
              result_o.sent_id = cfg_i.node_id;
            end else if (final_pass_q) begin
              stopped_d = 1'b1;
            end
          end
        end
        cbn_pkg::FUNC_FREE: begin
          if (!stopped_q) begin
            if (delivered_q) begin
              delivered_d       = 1'b0;
              final_pass_d      = 1'b1;
              result_o.free_ack = 1'b1;
            end else if (coll_seen_q) begin
              coll_seen_d = 1'b0;
              in_coll_d   = 1'b0;
              coll_d      = coll_inc;
              if (coll_inc >= cbn_pkg::MAX_ATTEMPTS) begin
                stopped_d = 1'b1;
              end else begin
                backoff_d = backoff_new;
              end
            end
          end
        end
        cbn_pkg::FUNC_COLLISION: begin
          in_coll_d = 1'b1;
        end
        cbn_pkg::FUNC_BLOCKED: begin
          blocked_d   = 1'b1;
          delivered_d = 1'b1;
        end
        default: ;
      endcase
      result_o.gave_up = stopped_d;
    end

    // Length write prepares a fresh frame
    if (cfg_i.length_wr) begin
      slots_d = frame_slots;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stopped_q    <= 1'b0;
      backoff_q    <= '0;
      coll_seen_q  <= 1'b0;
      in_coll_q    <= 1'b0;
      blocked_q    <= 1'b0;
      delivered_q  <= 1'b0;
      final_pass_q <= 1'b0;
      slots_q      <= {cbn_pkg::MEDIUM_LENGTH_RST, 1'b0};
      coll_q       <= '0;
    end else begin
      stopped_q    <= stopped_d;
      backoff_q    <= backoff_d;
      coll_seen_q  <= coll_seen_d;
      in_coll_q    <= in_coll_d;
      blocked_q    <= blocked_d;
      delivered_q  <= delivered_d;
      final_pass_q <= final_pass_d;
      slots_q      <= slots_d;
      coll_q       <= coll_d;
    end
  end

  assign status_o.stopped    = stopped_q;
  assign status_o.collisions = coll_q;

endmodule

FILE: sv/csma_cd_backoff_node_top.sv
// Top level of the CSMA/CD binary exponential backoff station.
// One event word is accepted per clock while the result side is not stalled, and
// yields exactly one result word; the accepting edge loads the input register, and
// the result register is loaded when the core steps the held event, which waits
// while the result register is full and m_axis_tready is low. Back-to-back events
// sustain one word per cycle when the output does not stall. The station state
// update in the core handles one event per clock in a single pass. Configuration
// is written over APB while the stream is idle; writing medium_length also reloads
// the frame slot counter through the registered length_wr strobe.
module csma_cd_backoff_node_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // APB configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cbn_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [cbn_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [cbn_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  // Event stream in
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [cbn_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // [9:0] random_draw
  input  logic [cbn_pkg::FUNC_W-1:0]        s_axis_tuser,  // [1:0] func
  // Result stream out
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [cbn_pkg::M_TDATA_W-1:0]     m_axis_tdata   // [7:0] sent_id, [8] free_ack,
                                                           // [9] gave_up
);

  cbn_pkg::cfg_t               cfg;
  cbn_pkg::result_t            core_res;
  cbn_pkg::status_t            status;

  logic                        in_valid_q, in_valid_d;
  cbn_pkg::func_e              in_func_q, in_func_d;
  logic [cbn_pkg::DRAW_W-1:0]  in_draw_q, in_draw_d;
  logic                        out_valid_q, out_valid_d;
  cbn_pkg::result_t            out_res_q, out_res_d;
  logic                        step;
  logic                        in_load;

  cbn_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Held event moves on when the result register is free or draining
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  cbn_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .func_i   (in_func_q),
    .draw_i   (in_draw_q),
    .cfg_i    (cfg),
    .result_o (core_res),
    .status_o (status)
  );

  // Input and result registers
  always_comb begin
    in_valid_d  = in_valid_q;
    in_func_d   = in_func_q;
    in_draw_d   = in_draw_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (in_load) begin
      in_valid_d = 1'b1;
      in_func_d  = cbn_pkg::func_e'(s_axis_tuser);
      in_draw_d  = s_axis_tdata[cbn_pkg::DRAW_W-1:0];
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    if (step) begin
      out_valid_d = 1'b1;
      out_res_d   = core_res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_func_q <= in_func_d;
    in_draw_q <= in_draw_d;
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = cbn_pkg::M_TDATA_W'(out_res_q);

`ifndef SYNTH
  // A stopped station never resumes
  a_stopped_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.stopped |=> status.stopped)
    else $error("station left the stopped state");

  // Collision count only moves when an event is processed
  a_coll_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(status.collisions))
    else $error("collision count changed without an event");

  // A held event is not dropped while the result side stalls
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step |=> in_valid_q && $stable(in_draw_q))
    else $error("held event lost while stalled");

  // No new event is taken while both registers are full and stalled
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted with pipeline full");
`endif

endmodule
